/* hw/rtl/fletcher_check_word_generator_defines.svh */
// Assertion macros shared by the checksum block.
// Each macro takes a label, the clock, the reset and the property terms.
`ifndef FLETCHER_CHECK_WORD_GENERATOR_DEFINES_SVH
`define FLETCHER_CHECK_WORD_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define FCWG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define FCWG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FCWG_ASSERT_NOW(label, clk, rst, ante, cons)
`define FCWG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/fcwg_pkg.sv */
`default_nettype none

package fcwg_pkg;

  // Field widths.
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [HALF_W-1:0] HALF_ONES = 16'hffff;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_SUM_A = 8'd0,
    CFG_START_SUM_B = 8'd1
  } cfg_reg_e;

  typedef logic [HALF_W-1:0] half_t;

  // One code item as it enters the block.
  typedef struct packed {
    logic [WORD_W-1:0] code_word;
    logic              is_double;
    logic              is_last;
  } code_item_t;

  // Input register contents seen by the summing core.
  typedef struct packed {
    logic       valid;
    code_item_t item;
  } stage_t;

  // Result handed from the core to the output register.
  typedef struct packed {
    logic  load;
    half_t check_word;
  } result_t;

  // Output register status seen by the core.
  typedef struct packed {
    logic free;
  } out_status_t;

  // Ones'-complement add: a carry out of bit 15 is added back into bit 0.
  function automatic half_t eac_add(input half_t x, input half_t y);
    logic [HALF_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[HALF_W-1:0] + {{(HALF_W-1){1'b0}}, s[HALF_W]};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/fcwg_ifs.sv */
`default_nettype none

// Code item channel.
interface fcwg_code_if import fcwg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] code_word;
  logic              is_double;
  logic              is_last;

  modport source (output valid, output code_word, output is_double, output is_last,
                  input ready);
  modport sink (input valid, input code_word, input is_double, input is_last,
                output ready);
endinterface

// Check word channel.
interface fcwg_check_if import fcwg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] check_word;

  modport source (output valid, output check_word, input ready);
  modport sink (input valid, input check_word, output ready);
endinterface

// Configuration write channel.
interface fcwg_cfg_if import fcwg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [HALF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fcwg_in_reg.sv */
`default_nettype none

module fcwg_in_reg
  import fcwg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  fcwg_code_if.sink code,
  input  wire logic advance,
  output stage_t    stage
);

  logic       valid;
  code_item_t item;

  // The register takes a new item whenever it is empty or drains this cycle.
  assign code.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (code.valid && code.ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (code.valid && code.ready) begin
      item.code_word <= code.code_word;
      item.is_double <= code.is_double;
      item.is_last   <= code.is_last;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

`default_nettype wire

/* hw/rtl/fcwg_sum_core.sv */
`default_nettype none

`include "fletcher_check_word_generator_defines.svh"

module fcwg_sum_core
  import fcwg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  fcwg_cfg_if.sink   cfg,
  input  stage_t     stage,
  input  out_status_t out_status,
  output logic       advance,
  output result_t    result
);

  half_t start_sum_a;
  half_t start_sum_b;
  half_t sum_a;
  half_t sum_b;
  logic  in_msg;

  half_t base_a;
  half_t base_b;
  half_t a_lo;
  half_t b_lo;
  half_t a_hi;
  half_t b_hi;
  half_t folded;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_sum_a <= '0;
      start_sum_b <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_START_SUM_A) begin
        start_sum_a <= cfg.data;
      end
      if (cfg.index == CFG_START_SUM_B) begin
        start_sum_b <= cfg.data;
      end
    end
  end

  // A last item may only move on when the output register can take its result.
  assign advance = stage.valid && (!stage.item.is_last || out_status.free);

  // A new message starts from the configured sums.
  assign base_a = in_msg ? sum_a : start_sum_a;
  assign base_b = in_msg ? sum_b : start_sum_b;

  // Low halfword, then the high halfword of a double word, then the final fold.
  always_comb begin
    a_lo = eac_add(base_a, stage.item.code_word[HALF_W-1:0]);
    b_lo = eac_add(base_b, a_lo);
    if (stage.item.is_double) begin
      a_hi = eac_add(a_lo, stage.item.code_word[WORD_W-1:HALF_W]);
      b_hi = eac_add(b_lo, a_hi);
    end else begin
      a_hi = a_lo;
      b_hi = b_lo;
    end
    folded = eac_add(b_hi, a_hi);
  end

  assign result.load       = advance && stage.item.is_last;
  assign result.check_word = HALF_ONES - folded;

  // Message state: a last item closes the message.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_msg <= 1'b0;
    end else if (advance) begin
      in_msg <= !stage.item.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum_a <= a_hi;
      sum_b <= b_hi;
    end
  end

  `FCWG_ASSERT_NOW(a_adv_needs_item, clk, rst, advance, stage.valid)
  `FCWG_ASSERT_NEXT(a_last_closes_msg, clk, rst, advance && stage.item.is_last, !in_msg)
  `FCWG_ASSERT_NEXT(a_mid_keeps_msg, clk, rst, advance && !stage.item.is_last, in_msg)
  `FCWG_ASSERT_NOW(a_load_has_room, clk, rst, result.load, out_status.free)

endmodule

`default_nettype wire

/* hw/rtl/fcwg_out_reg.sv */
`default_nettype none

module fcwg_out_reg
  import fcwg_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  result_t     result,
  output out_status_t out_status,
  fcwg_check_if.source check
);

  logic  valid;
  half_t check_word;

  // The register is free when empty or when its transaction completes now.
  assign out_status.free = !valid || check.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (result.load) begin
      valid <= 1'b1;
    end else if (check.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      check_word <= result.check_word;
    end
  end

  assign check.valid      = valid;
  assign check.check_word = check_word;

endmodule

`default_nettype wire

/* hw/rtl/fletcher_check_word_generator.sv */
// Fletcher-style check word generator. Each code item (a 32-bit word, a double
// flag and a last marker) adds its low halfword, and for a double word its high
// halfword, into two 16-bit ones'-complement sums A and B. The item marked last
// closes the message: A is folded into B and 0xffff minus B leaves on the check
// channel as one transaction. The sums then restart from start_sum_a and
// start_sum_b (register indexes 0 and 1), read when the first item of a message
// is summed. The block takes one item per cycle unless a last item waits. A
// held check word only stalls the next last item, not ordinary items. The
// chain of up to five 16-bit end-around-carry adds runs while an item sits in
// the input register, and a last item then loads its check word into the output register.
`default_nettype none

module fletcher_check_word_generator
  import fcwg_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  fcwg_code_if.sink    code,
  fcwg_check_if.source check,
  fcwg_cfg_if.sink     cfg
);

  stage_t      stage;
  result_t     result;
  out_status_t out_status;
  logic        advance;

  fcwg_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .code    (code),
    .advance (advance),
    .stage   (stage)
  );

  fcwg_sum_core u_sum_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .stage      (stage),
    .out_status (out_status),
    .advance    (advance),
    .result     (result)
  );

  fcwg_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .result     (result),
    .out_status (out_status),
    .check      (check)
  );

endmodule

`default_nettype wire

/* verif/fletcher_check_word_generator_tb.sv */
module fletcher_check_word_generator_tb
  import fcwg_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Flag values for the directed table.
  localparam bit SINGLE = 1'b0;
  localparam bit DOUBLE = 1'b1;
  localparam bit MORE   = 1'b0;
  localparam bit LAST   = 1'b1;

  // Register indexes that select no register.
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_IDX_W'(CFG_START_SUM_B + 1);
  localparam logic [CFG_IDX_W-1:0] TOP_UNUSED_IDX   = '1;

  localparam int unsigned ITEMS_PER_PHASE = 212;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned DRAIN_LIMIT     = 20000;

  // One directed code item; a known check word is given only for single-item
  // messages whose result is obvious.
  typedef struct {
    code_item_t item;
    bit         known;
    half_t      want;
  } directed_row_t;

  // Directed rows assume start sums of zero and a fresh message.
  directed_row_t directed_rows [16] = '{
    // All-zero word.
    '{'{32'h0000_0000, SINGLE, LAST}, 1'b1, 16'hffff},
    // All-ones double word: sums settle at negative zero.
    '{'{32'hffff_ffff, DOUBLE, LAST}, 1'b1, 16'h0000},
    // A single word ignores its high half.
    '{'{32'hffff_0000, SINGLE, LAST}, 1'b1, 16'hffff},
    '{'{32'h0000_ffff, SINGLE, LAST}, 1'b1, 16'h0000},
    '{'{32'h0001_0001, DOUBLE, LAST}, 1'b1, 16'hfffa},
    '{'{32'h0000_0001, SINGLE, LAST}, 1'b1, 16'hfffd},
    // Messages of one or more items with carries out of bit 15.
    '{'{32'h1234_5678, DOUBLE, MORE}, 1'b0, '0},
    '{'{32'hdead_beef, SINGLE, MORE}, 1'b0, '0},
    '{'{32'h8000_8000, DOUBLE, MORE}, 1'b0, '0},
    '{'{32'h7fff_0001, DOUBLE, LAST}, 1'b0, '0},
    '{'{32'haaaa_5555, DOUBLE, LAST}, 1'b0, '0},
    '{'{32'h5555_aaaa, DOUBLE, LAST}, 1'b0, '0},
    '{'{32'hffff_ffff, DOUBLE, MORE}, 1'b0, '0},
    '{'{32'hffff_ffff, DOUBLE, MORE}, 1'b0, '0},
    '{'{32'h0000_ffff, SINGLE, LAST}, 1'b0, '0},
    // Left open so that the next register write lands inside a message.
    '{'{32'h0f0f_f0f0, DOUBLE, MORE}, 1'b0, '0}
  };

  logic clk;
  logic rst;

  fcwg_code_if  code_bus ();
  fcwg_check_if check_bus ();
  fcwg_cfg_if   cfg_bus ();

  fletcher_check_word_generator u_dut (
    .clk   (clk),
    .rst   (rst),
    .code  (code_bus),
    .check (check_bus),
    .cfg   (cfg_bus)
  );

  // Predictor state: configured start sums and the running message sums.
  half_t base_a;
  half_t base_b;
  half_t run_a;
  half_t run_b;
  bit    msg_open;

  half_t       pending_checks [$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Ones'-complement 16-bit add with end-around carry.
  function automatic half_t ones_add(input half_t x, input half_t y);
    logic [HALF_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[HALF_W-1:0] + half_t'(s[HALF_W]);
  endfunction

  // Accumulates one accepted code item and queues the check word of a
  // closing item.
  function automatic void fold_code_item(input code_item_t it, input bit known,
                                         input half_t want);
    if (!msg_open) begin
      run_a    = base_a;
      run_b    = base_b;
      msg_open = 1'b1;
    end
    run_a = ones_add(run_a, it.code_word[HALF_W-1:0]);
    run_b = ones_add(run_b, run_a);
    if (it.is_double) begin
      run_a = ones_add(run_a, it.code_word[WORD_W-1:HALF_W]);
      run_b = ones_add(run_b, run_a);
    end
    if (it.is_last) begin
      pending_checks.push_back(known ? want : HALF_ONES - ones_add(run_b, run_a));
      msg_open = 1'b0;
    end
  endfunction

  // Halfword with extra weight on the extremes.
  function automatic half_t pick_half();
    case ($urandom_range(7))
      0: return '0;
      1: return HALF_ONES;
      default: return half_t'($urandom);
    endcase
  endfunction

  // Offers one code item after a random idle stretch and waits for the
  // transaction.
  task automatic send_code_item(input code_item_t it, input bit known, input half_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      code_bus.valid <= 1'b0;
      @(posedge clk);
    end
    code_bus.valid     <= 1'b1;
    code_bus.code_word <= it.code_word;
    code_bus.is_double <= it.is_double;
    code_bus.is_last   <= it.is_last;
    @(posedge clk);
    while (!code_bus.ready) @(posedge clk);
    fold_code_item(it, known, want);
  endtask

  // Register write transaction; only issued while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input half_t data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    if (idx == CFG_START_SUM_A) begin
      base_a = data;
    end else if (idx == CFG_START_SUM_B) begin
      base_b = data;
    end
  endtask

  // Waits for every queued check word, then for the pipeline to empty.
  task automatic settle_block();
    int unsigned waited;
    waited = 0;
    while (pending_checks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Check channel backpressure.
  always @(posedge clk) begin
    check_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compares each check word transaction with the oldest expectation.
  always @(posedge clk) begin
    half_t want;
    if (!rst && check_bus.valid && check_bus.ready) begin
      if (pending_checks.size() == 0) begin
        flag_error($sformatf("check word %h with none expected", check_bus.check_word));
      end else begin
        want = pending_checks.pop_front();
        if (check_bus.check_word !== want) begin
          flag_error($sformatf("check word %h, expected %h", check_bus.check_word, want));
        end
      end
    end
  end

  // Stimulus: reset, directed table, then three random phases with
  // different idling and start sums.
  initial begin
    int unsigned left_in_msg;
    code_item_t  it;

    rst                = 1'b1;
    code_bus.valid     = 1'b0;
    code_bus.code_word = '0;
    code_bus.is_double = 1'b0;
    code_bus.is_last   = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    base_a             = '0;
    base_b             = '0;
    run_a              = '0;
    run_b              = '0;
    msg_open           = 1'b0;
    error_count        = 0;
    send_idle_pct      = 22;
    recv_idle_pct      = 87;
    left_in_msg        = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_reg(CFG_START_SUM_A, '0);
    write_reg(CFG_START_SUM_B, '0);
    write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, TOP_UNUSED_IDX)),
              half_t'($urandom));

    foreach (directed_rows[i]) begin
      send_code_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);
    end
    code_bus.valid <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      settle_block();
      case (phase)
        0: begin
          write_reg(CFG_START_SUM_A, HALF_ONES);
          write_reg(CFG_START_SUM_B, HALF_ONES);
          write_reg(TOP_UNUSED_IDX, half_t'($urandom));
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 22;
          write_reg(CFG_START_SUM_B, half_t'($urandom));
          write_reg(CFG_START_SUM_A, half_t'($urandom));
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_reg(CFG_START_SUM_A, '0);
          write_reg(CFG_START_SUM_B, HALF_ONES);
          write_reg(FIRST_UNUSED_IDX, half_t'($urandom));
        end
      endcase

      // Mostly short messages so check words come often; a few long ones.
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (left_in_msg == 0) begin
          left_in_msg = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        end
        left_in_msg--;
        it.code_word = {pick_half(), pick_half()};
        it.is_double = 1'($urandom_range(1));
        it.is_last   = (left_in_msg == 0);
        send_code_item(it, 1'b0, '0);
      end
      code_bus.valid <= 1'b0;
    end

    settle_block();
    if (pending_checks.size() != 0) begin
      flag_error($sformatf("%0d check words never arrived", pending_checks.size()));
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
